FILE: sv/chobs_pkg.sv
// Shared types and constants for the cumulative histogram observe unit.
// No dependencies; every other file imports this package.
package chobs_pkg;

    localparam int MAX_BUCKETS   = 8;
    localparam int DATA_W        = 64;
    localparam int CFG_IDX_W     = $clog2(MAX_BUCKETS);
    localparam int DEF_BUCKETS   = 8;
    localparam int DEF_Q_DEPTH   = 4;

    localparam logic signed [DATA_W-1:0] BOUND_RESET = {1'b0, {(DATA_W-1){1'b1}}};

    // One classified sample: the value and which buckets it falls into.
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [MAX_BUCKETS-1:0]   hit;
    } item_t;

endpackage

FILE: sv/chobs_front.sv
// Front end: holds the bucket bounds and classifies each incoming sample.
// Depends on chobs_pkg.
module chobs_front import chobs_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [DATA_W-1:0] cfg_data,
    input  logic signed [DATA_W-1:0] sample_value,
    output item_t                    item
);

    logic signed [DATA_W-1:0] bound_reg [BUCKETS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BUCKETS; k++)
            begin
                bound_reg[k] <= BOUND_RESET;
            end
        end
        else if (cfg_we)
        begin
            // Writes to buckets beyond the configured count are dropped.
            for (int k = 0; k < BUCKETS; k++)
            begin
                if (cfg_index == CFG_IDX_W'(k))
                begin
                    bound_reg[k] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        item.sample = sample_value;
        item.hit    = '0;
        for (int k = 0; k < BUCKETS; k++)
        begin
            item.hit[k] = (sample_value <= bound_reg[k]);
        end
    end

endmodule

FILE: sv/chobs_queue.sv
// Short register queue that decouples the classifier from the counter stage.
// Depends on chobs_pkg.
module chobs_queue import chobs_pkg::*; #(
    parameter int DEPTH = DEF_Q_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  not_empty,
    output logic  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

FILE: sv/chobs_back.sv
// Back end: applies classified samples to the bucket counters, total count
// and running sum, and presents the updated totals as the result word.
// Depends on chobs_pkg.
module chobs_back import chobs_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  item_t                    head_item,
    input  logic                     head_valid,
    output logic                     pop,
    output logic [DATA_W-1:0]        counts [BUCKETS],
    output logic [DATA_W-1:0]        total,
    output logic signed [DATA_W-1:0] sum,
    output logic                     out_valid,
    input  logic                     out_stall
);

    logic [DATA_W-1:0]        count_reg [BUCKETS];
    logic [DATA_W-1:0]        total_reg;
    logic signed [DATA_W-1:0] sum_reg;
    logic                     valid_reg;

    // The counters double as the result register: a new sample is applied
    // only when the previous result has been taken or is taken this cycle.
    assign pop = head_valid && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BUCKETS; k++)
            begin
                count_reg[k] <= '0;
            end
            total_reg <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int k = 0; k < BUCKETS; k++)
                begin
                    count_reg[k] <= count_reg[k] + DATA_W'(head_item.hit[k]);
                end
                total_reg <= total_reg + DATA_W'(1);
                sum_reg   <= sum_reg + head_item.sample;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign counts    = count_reg;
    assign total     = total_reg;
    assign sum       = sum_reg;
    assign out_valid = valid_reg;

endmodule

FILE: sv/cumulative_histogram_observe_unit.sv
// Top level of the cumulative histogram observe unit.
// Depends on chobs_pkg, chobs_front, chobs_queue and chobs_back.
//
// Accepts one signed 64-bit sample per cycle while in_stall is low and
// returns one result word per sample carrying every bucket count, the total
// count and the running sum after that sample. An accepted sample is written
// into the queue and then applied to the counters, whose registers hold its
// result; the queue of QUEUE_DEPTH entries absorbs output stalls, and in_stall
// rises only when it is full. Sustained rate is one sample per cycle while
// out_stall is low, set by the combinational compare in front and the
// counter update in back. Bucket bounds reset to the largest signed value and
// may be written through the configuration port at any index below BUCKETS;
// buckets at or above BUCKETS report zero. All counters wrap modulo 2^64.
module cumulative_histogram_observe_unit import chobs_pkg::*; #(
    parameter int BUCKETS     = DEF_BUCKETS,
    parameter int QUEUE_DEPTH = DEF_Q_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic signed [DATA_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DATA_W-1:0]        count_bucket_0,
    output logic [DATA_W-1:0]        count_bucket_1,
    output logic [DATA_W-1:0]        count_bucket_2,
    output logic [DATA_W-1:0]        count_bucket_3,
    output logic [DATA_W-1:0]        count_bucket_4,
    output logic [DATA_W-1:0]        count_bucket_5,
    output logic [DATA_W-1:0]        count_bucket_6,
    output logic [DATA_W-1:0]        count_bucket_7,
    output logic [DATA_W-1:0]        samples_seen,
    output logic signed [DATA_W-1:0] sample_sum
);

    item_t             front_item;
    item_t             head_item;
    logic              q_not_empty;
    logic              q_full;
    logic              pop;
    logic              push;
    logic [DATA_W-1:0] counts      [BUCKETS];
    logic [DATA_W-1:0] counts_full [MAX_BUCKETS];

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    chobs_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_value (sample_value),
        .item         (front_item)
    );

    chobs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    chobs_back #(
        .BUCKETS (BUCKETS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (q_not_empty),
        .pop        (pop),
        .counts     (counts),
        .total      (samples_seen),
        .sum        (sample_sum),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    for (genvar k = 0; k < MAX_BUCKETS; k++)
    begin : g_counts
        if (k < BUCKETS)
        begin : g_active
            assign counts_full[k] = counts[k];
        end
        else
        begin : g_idle
            assign counts_full[k] = '0;
        end
    end

    assign count_bucket_0 = counts_full[0];
    assign count_bucket_1 = counts_full[1];
    assign count_bucket_2 = counts_full[2];
    assign count_bucket_3 = counts_full[3];
    assign count_bucket_4 = counts_full[4];
    assign count_bucket_5 = counts_full[5];
    assign count_bucket_6 = counts_full[6];
    assign count_bucket_7 = counts_full[7];

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for cumulative_histogram_observe_unit.
// Depends on chobs_pkg and the unit's RTL; predicts every result word and
// sweeps the bucket bounds through several settings between sampling phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chobs_pkg::*;

    localparam int BUCKETS         = DEF_BUCKETS;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int CYCLE_LIMIT     = 400000;

    typedef logic signed [DATA_W-1:0] sval_t;

    localparam sval_t SMAX = BOUND_RESET;
    localparam sval_t SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Everything one result word carries.
    typedef struct packed {
        logic [MAX_BUCKETS-1:0][DATA_W-1:0] counts;
        logic [DATA_W-1:0]                  seen;
        sval_t                              sum;
    } snapshot_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index    = '0;
    sval_t                    cfg_data     = '0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    sval_t                    sample_value = '0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic [DATA_W-1:0]        count_bucket_0, count_bucket_1, count_bucket_2, count_bucket_3;
    logic [DATA_W-1:0]        count_bucket_4, count_bucket_5, count_bucket_6, count_bucket_7;
    logic [DATA_W-1:0]        samples_seen;
    sval_t                    sample_sum;

    // Predicted state of the histogram.
    sval_t             bounds [MAX_BUCKETS];
    logic [DATA_W-1:0] bucket_tally [MAX_BUCKETS];
    logic [DATA_W-1:0] tally_all;
    sval_t             tally_sum;

    sval_t     samples_pending [$];
    snapshot_t snapshots_due [$];

    int gap_odds   = 0;
    int stall_odds = 0;
    int gap_left   = 0;
    int stall_left = 0;

    int errors          = 0;
    int results_checked = 0;
    int bound_writes    = 0;
    int bound_settings  = 1;
    int sum_wraps       = 0;
    int cycles          = 0;

    cumulative_histogram_observe_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .count_bucket_0 (count_bucket_0),
        .count_bucket_1 (count_bucket_1),
        .count_bucket_2 (count_bucket_2),
        .count_bucket_3 (count_bucket_3),
        .count_bucket_4 (count_bucket_4),
        .count_bucket_5 (count_bucket_5),
        .count_bucket_6 (count_bucket_6),
        .count_bucket_7 (count_bucket_7),
        .samples_seen   (samples_seen),
        .sample_sum     (sample_sum)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("no progress after %0d cycles, %0d results outstanding",
                   cycles, snapshots_due.size());
            $display("FAIL cumulative_histogram_observe_unit");
            $finish;
        end
    end

    // Applies one accepted sample to the predicted state and queues the
    // result word it must produce.
    function automatic void observe_sample(input sval_t s);
        snapshot_t snap;
        sval_t     new_sum;
        new_sum = tally_sum + s;
        if (tally_sum[DATA_W-1] == s[DATA_W-1] && new_sum[DATA_W-1] != s[DATA_W-1])
            sum_wraps++;
        for (int k = 0; k < MAX_BUCKETS; k++)
        begin
            if (k < BUCKETS && s <= bounds[k])
                bucket_tally[k] += 1;
            snap.counts[k] = (k < BUCKETS) ? bucket_tally[k] : '0;
        end
        tally_sum = new_sum;
        tally_all += 1;
        snap.seen = tally_all;
        snap.sum  = tally_sum;
        snapshots_due.push_back(snap);
    endfunction

    task automatic check_result();
        snapshot_t         want;
        logic [DATA_W-1:0] got [MAX_BUCKETS];
        got[0] = count_bucket_0;
        got[1] = count_bucket_1;
        got[2] = count_bucket_2;
        got[3] = count_bucket_3;
        got[4] = count_bucket_4;
        got[5] = count_bucket_5;
        got[6] = count_bucket_6;
        got[7] = count_bucket_7;
        if (snapshots_due.size() == 0)
        begin
            $error("result word with no sample outstanding, samples_seen %0d", samples_seen);
            errors++;
        end
        else
        begin
            want = snapshots_due.pop_front();
            for (int k = 0; k < MAX_BUCKETS; k++)
            begin
                if (got[k] !== want.counts[k])
                begin
                    $error("count_bucket_%0d: expected %0d, got %0d", k, want.counts[k], got[k]);
                    errors++;
                end
            end
            if (samples_seen !== want.seen)
            begin
                $error("samples_seen: expected %0d, got %0d", want.seen, samples_seen);
                errors++;
            end
            if (sample_sum !== want.sum)
            begin
                $error("sample_sum: expected %0d, got %0d", want.sum, sample_sum);
                errors++;
            end
            results_checked++;
        end
    endtask

    // Sample driver. The payload only moves once the current word is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                observe_sample(sample_value);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (samples_pending.size() > 0)
                begin
                    in_valid     <= 1'b1;
                    sample_value <= samples_pending.pop_front();
                    if (gap_odds > 0 && $urandom_range(gap_odds - 1, 0) == 0)
                        gap_left = $urandom_range(16, 1);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with bursty back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_odds > 0 && $urandom_range(stall_odds - 1, 0) == 0)
            begin
                stall_left = $urandom_range(15, 0);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_pending.size() != 0 || in_valid || snapshots_due.size() != 0);
    endtask

    task automatic write_bound(input int unsigned idx, input sval_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx < BUCKETS)
            bounds[idx] = value;
        bound_writes++;
    endtask

    task automatic load_bounds(input sval_t values [MAX_BUCKETS]);
        for (int k = 0; k < MAX_BUCKETS; k++)
            write_bound(k, values[k]);
        bound_settings++;
    endtask

    // Samples on or next to a bound, below a bound, near zero, at the range ends, or spread over the range.
    function automatic sval_t pick_sample();
        sval_t base;
        base = bounds[$urandom_range(MAX_BUCKETS - 1, 0)];
        case ($urandom_range(9, 0))
            0, 1, 2: return sval_t'({$urandom, $urandom});
            3, 4, 5: return base + sval_t'($urandom_range(2, 0)) - 1;
            6, 7:    return sval_t'($urandom_range(2000, 0)) - 1000;
            8:
            begin
                case ($urandom_range(3, 0))
                    0:       return SMIN;
                    1:       return SMIN + 1;
                    2:       return SMAX - 1;
                    default: return SMAX;
                endcase
            end
            default: return base - sval_t'($urandom_range(1000, 0));
        endcase
    endfunction

    initial
    begin
        sval_t chosen [MAX_BUCKETS];
        sval_t walk;
        int    kind;
        for (int k = 0; k < MAX_BUCKETS; k++)
        begin
            bounds[k]       = BOUND_RESET;
            bucket_tally[k] = '0;
        end
        tally_all  = '0;
        tally_sum  = '0;
        gap_odds   = 4;
        stall_odds = 4;
        wait (rst_n === 1'b1);

        // Bounds as they come out of reset: every bucket counts every sample,
        // and the repeated large values wrap the running sum both ways.
        samples_pending = {SMIN, SMAX, sval_t'(0), sval_t'(-1), sval_t'(1), SMAX, SMAX, SMIN};
        wait_drained();

        // Rising bounds; samples land exactly on, just above and just below them.
        chosen = '{-100, -10, -1, 0, 1, 10, 100, SMAX - 1};
        load_bounds(chosen);
        samples_pending = {sval_t'(-100), sval_t'(0), sval_t'(100), SMAX - 1, SMAX,
                           sval_t'(-101), sval_t'(101), SMIN};
        wait_drained();

        // Every bound at the most negative value: only that value is counted.
        for (int k = 0; k < MAX_BUCKETS; k++)
            chosen[k] = SMIN;
        load_bounds(chosen);
        samples_pending = {SMIN, SMIN + 1, SMAX};
        wait_drained();

        for (int k = 0; k < MAX_BUCKETS; k++)
            chosen[k] = (k % 2 == 0) ? SMIN : SMAX;
        load_bounds(chosen);
        samples_pending = {SMIN, sval_t'(0)};
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            kind = p % 4;
            walk = (kind == 0) ? sval_t'($urandom_range(2000, 0)) - 1000
                               : SMIN + sval_t'($urandom_range(1000, 0));
            for (int k = 0; k < MAX_BUCKETS; k++)
            begin
                case (kind)
                    0:
                    begin
                        chosen[k] = walk;
                        walk = walk + sval_t'($urandom_range(300, 0));
                    end
                    1: chosen[k] = sval_t'({$urandom, $urandom});
                    2:
                    begin
                        case ($urandom_range(5, 0))
                            0:       chosen[k] = SMIN;
                            1:       chosen[k] = SMIN + 1;
                            2:       chosen[k] = -1;
                            3:       chosen[k] = 0;
                            4:       chosen[k] = SMAX - 1;
                            default: chosen[k] = SMAX;
                        endcase
                    end
                    default:
                    begin
                        chosen[k] = walk;
                        walk = walk + sval_t'({4'b0000, 28'($urandom), $urandom});
                    end
                endcase
            end
            load_bounds(chosen);
            // No gaps or stalls in one phase in the middle, and again in the last phase.
            if (p == 3 || p == RANDOM_PHASES - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(12, 2);
                stall_odds = $urandom_range(12, 2);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                samples_pending.push_back(pick_sample());
            wait_drained();
        end

        repeat (4) @(posedge clk);
        $display("Checked %0d result words under %0d bound settings (%0d register writes).",
                 results_checked, bound_settings, bound_writes);
        $display("The running sum wrapped %0d times.", sum_wraps);
        if (errors == 0)
            $display("PASS cumulative_histogram_observe_unit");
        else
            $display("FAIL cumulative_histogram_observe_unit");
        $finish;
    end

endmodule
